// ----- rtl/core/bsd_pkg.sv -----
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types, constants and helper functions of the Bech32 symbol decoder.
// ----------------------------------------------------------------------------
package bsd_pkg;

   // number of trailing checksum symbols held back from the byte packer
   localparam int CHECK_SYMBOLS = 6;
   // entries of the queue between front and back
   localparam int QUEUE_DEPTH   = 2;

   // configuration port
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic CSR_IDX_RESIDUE = 1'b0;

   localparam int CHK_WIDTH = 30;
   localparam logic [CHK_WIDTH-1:0] CHK_INIT          = 30'd32;
   localparam logic [CHK_WIDTH-1:0] RESIDUE_RESET     = 30'h3fffffff;
   localparam logic [CHK_WIDTH-1:0] GEN0              = 30'h3b6a57b2;
   localparam logic [CHK_WIDTH-1:0] GEN1              = 30'h26508e6d;
   localparam logic [CHK_WIDTH-1:0] GEN2              = 30'h1ea119fa;
   localparam logic [CHK_WIDTH-1:0] GEN3              = 30'h3d4233dd;
   localparam logic [CHK_WIDTH-1:0] GEN4              = 30'h2a1462b3;

   // status codes
   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_BAD_CHAR     = 2'd1;
   localparam logic [1:0] ST_BAD_CHECKSUM = 2'd2;
   localparam logic [1:0] ST_TOO_SHORT    = 2'd3;

   // input item
   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } req_type;

   // result item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_status;
      logic [1:0] status;
      logic       run_last;
   } rsp_type;

   // classified item passed from front to back
   typedef struct packed {
      logic       ok;
      logic [4:0] sym;
      logic       last;
   } sym_type;

   // symbol alphabet, index is the 5-bit symbol value
   localparam logic [7:0] ALPHABET [32] = '{
      "q", "p", "z", "r", "y", "9", "x", "8",
      "g", "f", "2", "t", "v", "d", "w", "0",
      "s", "3", "j", "n", "5", "4", "k", "h",
      "c", "e", "6", "m", "u", "a", "7", "l"
   };

   // map a raw character to {found, symbol}; upper case folds to lower case
   function automatic logic [5:0] map_symbol(input logic [7:0] c);
      logic [7:0] lc;
      logic [5:0] res;
      lc  = c;
      res = '0;
      if (c >= "A" && c <= "Z") begin
         lc = c + 8'd32;
      end
      for (int i = 0; i < 32; i++) begin
         if (ALPHABET[i] == lc) begin
            res = {1'b1, 5'(i)};
         end
      end
      return res;
   endfunction

   // one step of the BCH polymod
   function automatic logic [CHK_WIDTH-1:0] poly_step(input logic [CHK_WIDTH-1:0] r,
                                                       input logic [4:0] v);
      logic [4:0]           top;
      logic [CHK_WIDTH-1:0] n;
      top = r[29:25];
      n   = {r[24:0], v};
      if (top[0]) n = n ^ GEN0;
      if (top[1]) n = n ^ GEN1;
      if (top[2]) n = n ^ GEN2;
      if (top[3]) n = n ^ GEN3;
      if (top[4]) n = n ^ GEN4;
      return n;
   endfunction

endpackage

// ----- rtl/core/bsd_front.sv -----
// ----------------------------------------------------------------------------
// bsd_front
// Front end: takes character transfers and classifies them into symbols.
// ----------------------------------------------------------------------------
module bsd_front (
   input  logic             req_valid,
   output logic             req_ready,
   input  bsd_pkg::req_type req_data,
   output logic             push_valid,
   input  logic             push_ready,
   output bsd_pkg::sym_type push_data
);

   logic [5:0] map_res;

   // alphabet lookup
   assign map_res = bsd_pkg::map_symbol(req_data.char_code);

   // classified item goes straight into the queue
   assign push_data.ok   = map_res[5];
   assign push_data.sym  = map_res[4:0];
   assign push_data.last = req_data.last;
   assign push_valid     = req_valid;
   assign req_ready      = push_ready;

endmodule

// ----- rtl/core/bsd_queue.sv -----
// ----------------------------------------------------------------------------
// bsd_queue
// Small FIFO between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module bsd_queue #(
   parameter int DEPTH = bsd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  bsd_pkg::sym_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output bsd_pkg::sym_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bsd_pkg::sym_type       mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/bsd_back.sv -----
// ----------------------------------------------------------------------------
// bsd_back
// Back end: polymod, checksum delay line, 5-to-8 bit repacking and the
// result register with one pending status slot.
// ----------------------------------------------------------------------------
module bsd_back #(
   parameter int CHECK_SYMBOLS = bsd_pkg::CHECK_SYMBOLS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [bsd_pkg::CHK_WIDTH-1:0]   expected_residue,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  bsd_pkg::sym_type                pop_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output bsd_pkg::rsp_type                rsp_data
);

   localparam int FILL_W = $clog2(CHECK_SYMBOLS + 1);

   // decode state
   logic [bsd_pkg::CHK_WIDTH-1:0] chk_ff, chk_in;
   logic [4:0]                    line_ff [CHECK_SYMBOLS];
   logic [4:0]                    line_in [CHECK_SYMBOLS];
   logic [FILL_W-1:0]             fill_ff, fill_in;
   logic [11:0]                   acc_ff, acc_in;
   logic [2:0]                    cnt_ff, cnt_in;
   logic                          bad_ff, bad_in;

   // result register and pending status
   logic                          out_valid_ff, out_valid_in;
   bsd_pkg::rsp_type              out_ff, out_in;
   logic                          pend_ff, pend_in;
   bsd_pkg::rsp_type              pend_res_ff, pend_res_in;

   logic                          do_pop;
   logic                          out_take;
   logic                          emit_byte;
   logic                          line_full;
   logic [11:0]                   acc_shift;
   logic [3:0]                    cnt_sum;
   logic [7:0]                    byte_val;
   logic [1:0]                    status_val;
   bsd_pkg::rsp_type              byte_res, status_res;

   assign out_take  = out_valid_ff & rsp_ready;
   assign pop_ready = ~pend_ff & (~out_valid_ff | rsp_ready);
   assign do_pop    = pop_valid & pop_ready;
   assign line_full = (fill_ff == FILL_W'(CHECK_SYMBOLS));
   assign acc_shift = {acc_ff[6:0], line_ff[0]};
   assign cnt_sum   = {1'b0, cnt_ff} + 4'd5;
   assign byte_val  = 8'(acc_shift >> cnt_sum[2:0]);

   // symbol processing for the item taken from the queue
   always_comb begin
      chk_in    = chk_ff;
      line_in   = line_ff;
      fill_in   = fill_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      bad_in    = bad_ff;
      emit_byte = 1'b0;
      if (do_pop) begin
         if (!pop_data.ok) begin
            bad_in = 1'b1;
         end else begin
            chk_in = bsd_pkg::poly_step(chk_ff, pop_data.sym);
            for (int i = 0; i + 1 < CHECK_SYMBOLS; i++) begin
               line_in[i] = line_ff[i+1];
            end
            line_in[CHECK_SYMBOLS-1] = pop_data.sym;
            if (line_full) begin
               acc_in = acc_shift;
               if (cnt_sum[3]) begin
                  cnt_in    = cnt_sum[2:0];
                  emit_byte = ~bad_ff;
               end else begin
                  cnt_in = cnt_sum[2:0];
               end
            end else begin
               fill_in = fill_ff + 1'b1;
            end
         end
      end

      // end-of-string status, by priority
      priority if (bad_in) begin
         status_val = bsd_pkg::ST_BAD_CHAR;
      end else if (fill_in != FILL_W'(CHECK_SYMBOLS)) begin
         status_val = bsd_pkg::ST_TOO_SHORT;
      end else if (chk_in != expected_residue) begin
         status_val = bsd_pkg::ST_BAD_CHECKSUM;
      end else begin
         status_val = bsd_pkg::ST_OK;
      end

      // clear for the next string
      if (do_pop && pop_data.last) begin
         chk_in  = bsd_pkg::CHK_INIT;
         fill_in = '0;
         acc_in  = '0;
         cnt_in  = '0;
         bad_in  = 1'b0;
      end
   end

   // result formatting
   always_comb begin
      byte_res.data_byte   = byte_val;
      byte_res.is_status   = 1'b0;
      byte_res.status      = bsd_pkg::ST_OK;
      byte_res.run_last    = ~pop_data.last;
      status_res.data_byte = '0;
      status_res.is_status = 1'b1;
      status_res.status    = status_val;
      status_res.run_last  = 1'b1;
   end

   // result register: pending status first, then new results
   always_comb begin
      out_valid_in = out_valid_ff & ~out_take;
      out_in       = out_ff;
      pend_in      = pend_ff;
      pend_res_in  = pend_res_ff;
      if (pend_ff && (out_take || !out_valid_ff)) begin
         out_in       = pend_res_ff;
         out_valid_in = 1'b1;
         pend_in      = 1'b0;
      end else if (do_pop) begin
         if (emit_byte) begin
            out_in       = byte_res;
            out_valid_in = 1'b1;
            if (pop_data.last) begin
               pend_in     = 1'b1;
               pend_res_in = status_res;
            end
         end else if (pop_data.last) begin
            out_in       = status_res;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ff       <= bsd_pkg::CHK_INIT;
         fill_ff      <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         bad_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         chk_ff       <= chk_in;
         fill_ff      <= fill_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         bad_ff       <= bad_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      line_ff     <= line_in;
      out_ff      <= out_in;
      pend_res_ff <= pend_res_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- rtl/core/bech32_symbol_decode_core.sv -----
// ----------------------------------------------------------------------------
// bech32_symbol_decode_core
// Streaming Bech32 symbol decoder: characters in, payload bytes and status out.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one character per transfer with a last-of-string flag.
//   rsp_* returns decoded bytes and, after the last character, one status
//   result (ok, bad character, bad checksum, too short). Bytes are
//   provisional; keep them only if the following status is ok.
//   The APB port holds expected_residue at address 0 (reset 0x3fffffff);
//   write it only while the block is idle.
// Path: each character's result passes through the queue register, then
//   the result register.
// Throughput: one character per cycle while rsp_ready is high. A last
//   character that also completes a byte gives two results and holds the
//   back end while its status waits for the single output port.
// Reset clears the queue, decode state and result register; the string in
//   progress is dropped. When rsp_ready is low, the result register holds and
//   the two-entry queue absorbs characters before req_ready drops.
// ----------------------------------------------------------------------------
module bech32_symbol_decode_core #(
   parameter int CHECK_SYMBOLS = bsd_pkg::CHECK_SYMBOLS,
   parameter int QUEUE_DEPTH   = bsd_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bsd_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bsd_pkg::rsp_type                    rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bsd_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [bsd_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [bsd_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready
);

   logic [bsd_pkg::CHK_WIDTH-1:0] residue_ff, residue_in;
   logic                          csr_write;
   logic                          push_valid, push_ready;
   bsd_pkg::sym_type              push_data;
   logic                          pop_valid, pop_ready;
   bsd_pkg::sym_type              pop_data;

   // configuration register
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      residue_in = residue_ff;
      if (csr_write && paddr[2] == bsd_pkg::CSR_IDX_RESIDUE) begin
         residue_in = pwdata[bsd_pkg::CHK_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         residue_ff <= bsd_pkg::RESIDUE_RESET;
      end else begin
         residue_ff <= residue_in;
      end
   end

   assign prdata = (paddr[2] == bsd_pkg::CSR_IDX_RESIDUE) ?
                   bsd_pkg::CSR_DATA_WIDTH'(residue_ff) : '0;

   // front end: character classification
   bsd_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decoupling queue
   bsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back end: checksum, repacking, results
   bsd_back #(
      .CHECK_SYMBOLS (CHECK_SYMBOLS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .expected_residue (residue_ff),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

`ifndef SYNTHESIS
   // a byte that is not the last result of its character is followed by status
   a_status_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.run_last |=> rsp_valid && rsp_data.is_status)
      else $error("byte with pending status not followed by status result");

   // byte results never carry a status code
   a_byte_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_status |-> rsp_data.status == bsd_pkg::ST_OK)
      else $error("byte result carries a status code");

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bech32_symbol_decode_core. Character strings go in
// over the req channel: hand-picked corner strings first, then random strings.
// Most random strings are well formed, with a checksum built for the residue
// currently programmed. The rest carry a flipped symbol, an invalid
// character, too few symbols, or are noise. A tracker class mirrors the
// decoder state, queues the expected bytes and status results, and checks
// every rsp transfer field by field. Both channels stall at random, and the
// residue register is reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------

// character of a 5-bit symbol
function automatic logic [7:0] symbol_char(logic [4:0] s);
   string alphabet_text;
   alphabet_text = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
   return 8'(alphabet_text[s]);
endfunction

// symbol value of a character, -1 if outside the alphabet
function automatic int symbol_of(logic [7:0] c);
   logic [7:0] lc;
   lc = c;
   if (c >= "A" && c <= "Z") lc = c | 8'h20;
   for (int k = 0; k < 32; k++) begin
      if (symbol_char(5'(k)) == lc) return k;
   end
   return -1;
endfunction

// one polymod step
function automatic bit [29:0] mix_symbol(bit [29:0] r, bit [4:0] v);
   bit [29:0] gens [5];
   bit [29:0] n;
   gens = '{bsd_pkg::GEN0, bsd_pkg::GEN1, bsd_pkg::GEN2, bsd_pkg::GEN3, bsd_pkg::GEN4};
   n    = {r[24:0], v};
   for (int k = 0; k < 5; k++) begin
      if (r[25+k]) n = n ^ gens[k];
   end
   return n;
endfunction

// Mirror of the decoder: expected results per accepted character
class bech32_tracker;
   bit [29:0]        residue;
   bit [29:0]        chk;
   bit [4:0]         line [bsd_pkg::CHECK_SYMBOLS];
   int unsigned      fill;
   bit [11:0]        acc;
   bit [3:0]         nbits;
   bit               bad_seen;
   bsd_pkg::rsp_type pending_outputs [$];
   int unsigned      failures;

   function new();
      residue  = bsd_pkg::RESIDUE_RESET;
      failures = 0;
      clear();
   endfunction

   // end of string: decode state back to its reset values
   function void clear();
      chk      = bsd_pkg::CHK_INIT;
      fill     = 0;
      acc      = '0;
      nbits    = '0;
      bad_seen = 1'b0;
      foreach (line[k]) line[k] = '0;
   endfunction

   // accepted character: advance state, queue the results it causes
   function void take_char(bsd_pkg::req_type item);
      int               code;
      bsd_pkg::rsp_type res;
      bit [4:0]         out_sym;
      bit [1:0]         st;
      code = symbol_of(item.char_code);
      if (code < 0) begin
         bad_seen = 1'b1;
      end else begin
         chk = mix_symbol(chk, code[4:0]);
         if (fill >= bsd_pkg::CHECK_SYMBOLS) begin
            // oldest symbol leaves the delay line into the byte packer
            out_sym = line[0];
            for (int k = 0; k < bsd_pkg::CHECK_SYMBOLS - 1; k++) line[k] = line[k+1];
            line[bsd_pkg::CHECK_SYMBOLS-1] = code[4:0];
            acc   = {acc[6:0], out_sym};
            nbits = nbits + 4'd5;
            if (nbits[3]) begin
               nbits[3] = 1'b0;
               if (!bad_seen) begin
                  res           = '0;
                  res.data_byte = 8'(acc >> nbits);
                  res.run_last  = !item.last;
                  pending_outputs.insert(pending_outputs.size(), res);
               end
            end
         end else begin
            line[fill] = code[4:0];
            fill++;
         end
      end
      // end of string: status by priority
      if (item.last) begin
         if (bad_seen)                              st = bsd_pkg::ST_BAD_CHAR;
         else if (fill < bsd_pkg::CHECK_SYMBOLS)    st = bsd_pkg::ST_TOO_SHORT;
         else if (chk != residue)                   st = bsd_pkg::ST_BAD_CHECKSUM;
         else                                       st = bsd_pkg::ST_OK;
         res           = '0;
         res.is_status = 1'b1;
         res.status    = st;
         res.run_last  = 1'b1;
         pending_outputs.insert(pending_outputs.size(), res);
         clear();
      end
   endfunction

   // rsp transfer against the oldest expectation
   function void match_output(bsd_pkg::rsp_type got);
      bsd_pkg::rsp_type want;
      bit               bad;
      bad = 1'b0;
      if (pending_outputs.size() == 0) begin
         $error("result with nothing expected: %h", got);
         failures++;
         return;
      end
      want = pending_outputs.pop_front();
      if (got.data_byte !== want.data_byte) begin
         $error("data_byte: expected %0h, actual %0h", want.data_byte, got.data_byte);
         bad = 1'b1;
      end
      if (got.is_status !== want.is_status) begin
         $error("is_status: expected %0d, actual %0d", want.is_status, got.is_status);
         bad = 1'b1;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, got.status);
         bad = 1'b1;
      end
      if (got.run_last !== want.run_last) begin
         $error("run_last: expected %0d, actual %0d", want.run_last, got.run_last);
         bad = 1'b1;
      end
      if (bad) failures++;
   endfunction
endclass

module tb;

   typedef logic [7:0] text_type [$];
   typedef logic [4:0] syms_type [$];

   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int          PHASE_CHARS  = 80;
   localparam int          IDLE_PCT     = 18;

   logic                               clock     = 1'b0;
   logic                               reset     = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   bsd_pkg::req_type                   req_data  = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   bsd_pkg::rsp_type                   rsp_data;
   logic                               psel      = 1'b0;
   logic                               penable   = 1'b0;
   logic                               pwrite    = 1'b0;
   logic [bsd_pkg::CSR_ADDR_WIDTH-1:0] paddr     = '0;
   logic [bsd_pkg::CSR_DATA_WIDTH-1:0] pwdata    = '0;
   logic [bsd_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic                               pready;

   bech32_tracker decode_track;
   bit            steady      = 1'b0;
   int unsigned   chars_sent  = 0;
   int unsigned   cycle_count = 0;

   bech32_symbol_decode_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side: random back-pressure, check each rsp transfer
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) decode_track.match_output(rsp_data);
   end

   // character with random case for letters
   function automatic logic [7:0] spell(logic [4:0] s, int upper_pct);
      logic [7:0] c;
      c = symbol_char(s);
      if (c >= "a" && c <= "z" && $urandom_range(99) < upper_pct) c = c - 8'd32;
      return c;
   endfunction

   function automatic syms_type random_syms(int n);
      syms_type q;
      repeat (n) q.insert(q.size(), 5'($urandom_range(31)));
      return q;
   endfunction

   function automatic logic [7:0] invalid_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (symbol_of(c) >= 0);
      return c;
   endfunction

   // data symbols plus six check symbols that land the polymod on target
   function automatic text_type encode(syms_type data, logic [29:0] target, int upper_pct);
      text_type    text;
      logic [29:0] r;
      logic [29:0] diff;
      r = bsd_pkg::CHK_INIT;
      foreach (data[k]) r = mix_symbol(r, data[k]);
      repeat (bsd_pkg::CHECK_SYMBOLS) r = mix_symbol(r, 5'd0);
      diff = r ^ target;
      for (int k = 0; k < bsd_pkg::CHECK_SYMBOLS; k++) begin
         data.insert(data.size(), diff[5*(5-k) +: 5]);
      end
      foreach (data[k]) text.insert(text.size(), spell(data[k], upper_pct));
      return text;
   endfunction

   // one req transfer, with an optional random gap ahead of it
   task automatic send_char(logic [7:0] code, logic is_last);
      bsd_pkg::req_type item;
      int               gap;
      item.char_code = code;
      item.last      = is_last;
      gap = (!steady && $urandom_range(99) < IDLE_PCT) ? $urandom_range(1, 3) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_track.take_char(item);
      chars_sent++;
   endtask

   task automatic send_string(text_type text);
      foreach (text[k]) send_char(text[k], k == text.size() - 1);
   endtask

   // drop valid and wait until every expected result has come out
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (decode_track.pending_outputs.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // APB write of expected_residue, then read it back
   task automatic program_residue(logic [29:0] value);
      logic [bsd_pkg::CSR_ADDR_WIDTH-1:0] addr;
      addr    = '0;
      addr[2] = bsd_pkg::CSR_IDX_RESIDUE;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {{(bsd_pkg::CSR_DATA_WIDTH - bsd_pkg::CHK_WIDTH){1'b0}}, value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[bsd_pkg::CHK_WIDTH-1:0] !== value) begin
         $error("expected_residue: expected %0h, actual %0h", value,
                prdata[bsd_pkg::CHK_WIDTH-1:0]);
         decode_track.failures++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      decode_track.residue = value;
   endtask

   // random strings, mostly well formed, until the phase quota is reached
   task automatic run_phase(logic [29:0] target, int unsigned count);
      text_type    text;
      int unsigned stop;
      int          kind;
      int          len;
      int          pos;
      int          sym;
      stop = chars_sent + count;
      while (chars_sent < stop) begin
         kind = $urandom_range(99);
         len  = ($urandom_range(9) < 8) ? $urandom_range(0, 12) : $urandom_range(13, 40);
         text = encode(random_syms(len), target, $urandom_range(2) * 50);
         if (kind >= 60 && kind < 70) begin
            // one symbol changed: checksum must fail
            pos = $urandom_range(text.size() - 1);
            sym = symbol_of(text[pos]);
            text[pos] = spell(5'(sym) ^ 5'($urandom_range(1, 31)), 50);
         end else if (kind >= 70 && kind < 80) begin
            // invalid character inserted anywhere, the end included
            pos = $urandom_range(text.size());
            text.insert(pos, invalid_char());
         end else if (kind >= 80 && kind < 90) begin
            // fewer symbols than the check length
            text.delete();
            repeat ($urandom_range(1, bsd_pkg::CHECK_SYMBOLS - 1)) begin
               text.insert(text.size(), spell(5'($urandom_range(31)), 50));
            end
         end else if (kind >= 90) begin
            // noise: raw bytes mixed with alphabet characters
            text.delete();
            repeat ($urandom_range(1, 10)) begin
               if ($urandom_range(1)) text.insert(text.size(), 8'($urandom_range(255)));
               else text.insert(text.size(), spell(5'($urandom_range(31)), 50));
            end
         end
         send_string(text);
      end
   endtask

   initial begin
      logic [29:0] targets [5];
      syms_type    corner;
      syms_type    none;
      decode_track = new();
      targets = '{bsd_pkg::RESIDUE_RESET, 30'h0, 30'h1, 30'($urandom()), 30'h2bc830a3};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corner strings at the reset residue
      send_string('{8'hff});
      send_string('{8'h00});
      send_string('{"q", "p"});
      corner = '{5'd31, 5'd31, 5'd31, 5'd31, 5'd0, 5'd0, 5'd0, 5'd0};
      send_string(encode(corner, bsd_pkg::RESIDUE_RESET, 100));
      send_string(encode(none, bsd_pkg::RESIDUE_RESET, 0));

      // random phases, one residue each; one phase without any idling
      foreach (targets[p]) begin
         quiesce();
         program_residue(targets[p]);
         steady = (p == 2);
         run_phase(targets[p], PHASE_CHARS);
      end
      steady = 1'b0;
      quiesce();
      repeat (10) @(posedge clock);

      if (decode_track.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/bsd_pkg.sv
rtl/core/bsd_front.sv
rtl/core/bsd_queue.sv
rtl/core/bsd_back.sv
rtl/core/bech32_symbol_decode_core.sv
bench/tb.sv
